// ===== rtl/core/bpfm_pkg.sv =====
// bpfm_pkg: shared types, constants and helpers of the byte pattern first match unit.
// Used by bpfm_cell, bpfm_out_buf, byte_pattern_first_match_unit and the bench; depends on nothing.
`default_nettype none

package bpfm_pkg;

    // default sizing, handed to the top level parameters
    localparam int BUFFER_SIZE_DEF = 4096;
    localparam int PATTERN_MAX_DEF = 16;

    // fixed widths of the register and result fields
    localparam int PAT_BYTES = 16;
    localparam int LEN_W     = 5;
    localparam int OFS_W     = 12;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 64;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT_LO  = 3'd0,
        CFG_PAT_HI  = 3'd1,
        CFG_PAT_LEN = 3'd2,
        CFG_START   = 3'd3
    } t_cfg_idx;

    // per-beat control handed to every window cell
    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctl;

    // pick pattern byte idx out of the 16-byte pattern word
    function automatic logic [7:0] pat_byte(input logic [8*PAT_BYTES-1:0] pat,
                                            input logic [3:0] idx);
        return pat[{idx, 3'b000} +: 8];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bpfm_cell.sv =====
// bpfm_cell: one byte of the sliding window; shifts its neighbor's byte in and compares.
// Depends on bpfm_pkg.
`default_nettype none

module bpfm_cell (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire bpfm_pkg::t_cell_ctl i_ctl,
    input  wire logic [7:0]          i_byte,
    input  wire logic [7:0]          i_expect,
    input  wire logic                i_use,
    output logic [7:0]               o_byte,
    output logic                     o_hit
);
    import bpfm_pkg::*;

    logic [7:0] r_byte;
    logic [7:0] n_byte;

    // clear at end of buffer, else take the neighbor's byte on a shift
    always_comb begin
        n_byte = r_byte;
        if (i_ctl.clear) begin
            n_byte = 8'd0;
        end else if (i_ctl.shift) begin
            n_byte = i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= 8'd0;
        end else begin
            r_byte <= n_byte;
        end
    end

    // compare the byte that enters this cell on the current beat
    assign o_hit  = !i_use || (i_byte == i_expect);
    assign o_byte = r_byte;

endmodule

`default_nettype wire

// ===== rtl/core/bpfm_out_buf.sv =====
// bpfm_out_buf: result register plus skid entry on the master stream side.
// Depends on bpfm_pkg.
`default_nettype none

module bpfm_out_buf (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire logic                       i_found,
    input  wire logic [bpfm_pkg::OFS_W-1:0] i_offset,
    output logic                            o_ready,
    output logic                            o_tvalid,
    input  wire logic                       i_tready,
    output logic [bpfm_pkg::OFS_W-1:0]      o_offset,
    output logic                            o_found
);
    import bpfm_pkg::*;

    logic             r_out_valid, n_out_valid;
    logic             r_out_found, n_out_found;
    logic [OFS_W-1:0] r_out_ofs,   n_out_ofs;
    logic             r_skid_valid, n_skid_valid;
    logic             r_skid_found, n_skid_found;
    logic [OFS_W-1:0] r_skid_ofs,   n_skid_ofs;
    logic             w_pop;

    assign w_pop = r_out_valid && i_tready;

    // move skid forward on a pop, park a new result in skid when the head is stuck
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_found  = r_out_found;
        n_out_ofs    = r_out_ofs;
        n_skid_valid = r_skid_valid;
        n_skid_found = r_skid_found;
        n_skid_ofs   = r_skid_ofs;
        if (w_pop) begin
            if (r_skid_valid) begin
                n_out_found  = r_skid_found;
                n_out_ofs    = r_skid_ofs;
                n_skid_valid = 1'b0;
            end else if (i_push) begin
                n_out_found = i_found;
                n_out_ofs   = i_offset;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid) begin
                n_out_valid = 1'b1;
                n_out_found = i_found;
                n_out_ofs   = i_offset;
            end else begin
                n_skid_valid = 1'b1;
                n_skid_found = i_found;
                n_skid_ofs   = i_offset;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_found  <= n_out_found;
        r_out_ofs    <= n_out_ofs;
        r_skid_found <= n_skid_found;
        r_skid_ofs   <= n_skid_ofs;
    end

    assign o_ready  = !r_skid_valid;
    assign o_tvalid = r_out_valid;
    assign o_found  = r_out_found;
    assign o_offset = r_out_ofs;

    // skid holds data only behind a waiting head
    a_skid_behind_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid with empty head");

    // a full skid entry stays until a pop
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !w_pop) |=> r_skid_valid)
        else $error("skid entry lost without a pop");

    // a stalled head stays valid and keeps its offset
    a_head_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_tready) |=> (r_out_valid && $stable(r_out_ofs)))
        else $error("stalled result changed");

endmodule

`default_nettype wire

// ===== rtl/core/byte_pattern_first_match_unit.sv =====
// byte_pattern_first_match_unit: finds the first offset of a byte pattern in a byte stream.
// Depends on bpfm_pkg, bpfm_cell and bpfm_out_buf.
//
//   Channel   Dir  Handshake                Payload
//   s (in)    in   i_s_tvalid/o_s_tready     tdata[7:0] data_byte, tlast last_byte
//   m (out)   out  o_m_tvalid/i_m_tready     tdata[11:0] match_offset, tuser found
//   cfg       in   i_cfg_we                  i_cfg_index, i_cfg_data[63:0]
//
// One byte per cycle: the window is a row of PATTERN_MAX cells shifted on each beat,
// and every cell compares in the same cycle, so the result is registered in the next cycle.
// A result waits in a head register with one skid entry behind it; input stalls only
// when both are full. Reset (synchronous, active low) clears the window, the byte
// position, the match flag and the result queue; no clearing pass is needed.
`default_nettype none

module byte_pattern_first_match_unit #(
    parameter int BUFFER_SIZE = bpfm_pkg::BUFFER_SIZE_DEF,
    parameter int PATTERN_MAX = bpfm_pkg::PATTERN_MAX_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // slave stream: tdata = {data_byte[7:0]}
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    input  wire logic [7:0]                     i_s_tdata,
    input  wire logic                           i_s_tlast,
    // master stream: tdata = {pad[15:12], match_offset[11:0]}, tuser = {found}
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    output logic [15:0]                         o_m_tdata,
    output logic                                o_m_tuser,
    // configuration write port
    input  wire logic                           i_cfg_we,
    input  wire logic [bpfm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [bpfm_pkg::CFG_W-1:0]     i_cfg_data
);
    import bpfm_pkg::*;

    localparam int POS_W   = $clog2(BUFFER_SIZE + 1);
    localparam int CW      = (POS_W + 1 > OFS_W) ? POS_W + 1 : OFS_W;
    localparam int LEN_CAP = (PATTERN_MAX < PAT_BYTES) ? PATTERN_MAX : PAT_BYTES;

    // configuration registers
    logic [CFG_W-1:0] r_pat_lo;
    logic [CFG_W-1:0] r_pat_hi;
    logic [LEN_W-1:0] r_pat_len;
    logic [OFS_W-1:0] r_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo  <= '0;
            r_pat_hi  <= '0;
            r_pat_len <= LEN_W'(1);
            r_start   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PAT_LO:  r_pat_lo  <= i_cfg_data;
                CFG_PAT_HI:  r_pat_hi  <= i_cfg_data;
                CFG_PAT_LEN: r_pat_len <= i_cfg_data[LEN_W-1:0];
                CFG_START:   r_start   <= i_cfg_data[OFS_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp the pattern length into 1..LEN_CAP
    logic [LEN_W-1:0]         w_len;
    logic [8*PAT_BYTES-1:0]   w_pat;

    always_comb begin
        w_len = r_pat_len;
        if (r_pat_len == '0) begin
            w_len = LEN_W'(1);
        end else if (r_pat_len > LEN_W'(LEN_CAP)) begin
            w_len = LEN_W'(LEN_CAP);
        end
    end

    assign w_pat = {r_pat_hi, r_pat_lo};

    // buffer tracking
    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_answered, n_answered;
    logic             w_acc;
    logic             w_active;
    t_cell_ctl        w_ctl;
    logic             w_buf_ready;

    assign w_acc       = i_s_tvalid && w_buf_ready;
    assign w_active    = r_pos < POS_W'(BUFFER_SIZE);
    assign w_ctl.shift = w_acc && w_active;
    assign w_ctl.clear = w_acc && i_s_tlast;
    assign o_s_tready  = w_buf_ready;

    // row of window cells, newest byte in cell 0
    logic [7:0]             w_win   [PATTERN_MAX];
    logic [7:0]             w_exp   [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] w_use;
    logic [PATTERN_MAX-1:0] w_hit;

    for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
        logic [7:0] w_in;
        logic [3:0] w_idx;

        if (k == 0) begin : g_head
            assign w_in = i_s_tdata;
        end else begin : g_link
            assign w_in = w_win[k-1];
        end

        // cell k lines up with pattern byte len-1-k
        if (k < PAT_BYTES) begin : g_cmp
            assign w_use[k] = LEN_W'(k) < w_len;
            assign w_idx    = 4'(w_len - LEN_W'(k) - LEN_W'(1));
            assign w_exp[k] = pat_byte(w_pat, w_idx);
        end else begin : g_nocmp
            assign w_use[k] = 1'b0;
            assign w_idx    = 4'd0;
            assign w_exp[k] = 8'(w_idx);
        end

        bpfm_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl),
            .i_byte   (w_in),
            .i_expect (w_exp[k]),
            .i_use    (w_use[k]),
            .o_byte   (w_win[k]),
            .o_hit    (w_hit[k])
        );
    end

    // start position of a pattern ending on this byte, and its checks
    logic [CW-1:0]    w_end1;
    logic [CW-1:0]    w_s;
    logic             w_match;
    logic             w_nf;
    logic             w_push;
    logic [OFS_W-1:0] w_ofs;

    assign w_end1  = CW'(r_pos) + CW'(1);
    assign w_s     = w_end1 - CW'(w_len);
    assign w_match = w_ctl.shift && !r_answered && (w_end1 >= CW'(w_len))
                     && (w_s >= CW'(r_start)) && (&w_hit);
    assign w_nf    = w_acc && i_s_tlast && !r_answered && !w_match;
    assign w_push  = w_match || w_nf;
    assign w_ofs   = w_match ? w_s[OFS_W-1:0] : '0;

    // advance position, latch the match, reset both at end of buffer
    always_comb begin
        n_pos      = r_pos;
        n_answered = r_answered;
        if (w_ctl.clear) begin
            n_pos      = '0;
            n_answered = 1'b0;
        end else begin
            if (w_ctl.shift) begin
                n_pos = r_pos + POS_W'(1);
            end
            if (w_match) begin
                n_answered = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_answered <= 1'b0;
        end else begin
            r_pos      <= n_pos;
            r_answered <= n_answered;
        end
    end

    // result queue toward the master side
    logic [OFS_W-1:0] w_out_ofs;

    bpfm_out_buf u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_found  (w_match),
        .i_offset (w_ofs),
        .o_ready  (w_buf_ready),
        .o_tvalid (o_m_tvalid),
        .i_tready (i_m_tready),
        .o_offset (w_out_ofs),
        .o_found  (o_m_tuser)
    );

    assign o_m_tdata = {{(16 - OFS_W){1'b0}}, w_out_ofs};

    // position never runs past the buffer size
    a_pos_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(BUFFER_SIZE))
        else $error("byte position past buffer size");

    // a match is reported only after at least one byte of the buffer
    a_answered_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_answered |-> (r_pos != '0))
        else $error("match flag set at buffer start");

    // the final byte always restarts the buffer state
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_s_tlast) |=> (r_pos == '0 && !r_answered))
        else $error("buffer state not cleared after final byte");

endmodule

`default_nettype wire

// ===== verif/tb_byte_pattern_first_match_unit.sv =====
// tb_byte_pattern_first_match_unit: self-checking bench for the byte pattern first match unit.
// Depends on bpfm_pkg and byte_pattern_first_match_unit; tracks the search on its own,
// streams buffers under random sender gaps and receiver stalls, checks every result beat.
`timescale 1ns / 100ps

module tb_byte_pattern_first_match_unit;

    import bpfm_pkg::*;

    localparam int BUF_BYTES    = BUFFER_SIZE_DEF;
    localparam int WIN_BYTES    = PATTERN_MAX_DEF;
    localparam int RANDOM_BEATS = 620;
    localparam int IDLE_LIMIT   = 2000;
    localparam int SETTLE_CYC   = 4;
    localparam int TAIL_CYC     = 8;
    // first register index that maps to no register
    localparam int CFG_IDX_SPARE = 4;

    typedef struct packed {
        logic             found;
        logic [OFS_W-1:0] offset;
    } t_search_answer;

    typedef enum int {RX_STEADY, RX_COIN, RX_SPARSE, RX_PERIODIC} t_rx_mode;

    // DUT connections
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_s_tvalid  = 1'b0;
    logic                 o_s_tready;
    logic [7:0]           i_s_tdata   = '0;
    logic                 i_s_tlast   = 1'b0;
    logic                 o_m_tvalid;
    logic                 i_m_tready  = 1'b1;
    logic [15:0]          o_m_tdata;
    logic                 o_m_tuser;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data  = '0;

    // search tracker: configuration copy and window state
    logic [CFG_W-1:0] pat_lo;
    logic [CFG_W-1:0] pat_hi;
    logic [LEN_W-1:0] pat_len;
    logic [OFS_W-1:0] start_ofs;
    logic [7:0]       window [WIN_BYTES];
    int unsigned      byte_pos;
    bit               answered;

    t_search_answer pending_answers[$];

    // run bookkeeping
    int       beats_sent;
    int       buffers_sent;
    int       answers_seen;
    int       mismatch_count;
    int       idle_cycles;
    int       burst_left;
    bit       gaps_on;
    t_rx_mode rx_mode;
    int       rx_hold;
    int       rx_tick;

    byte_pattern_first_match_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // search tracker
    // ------------------------------------------------------------------

    function automatic logic [7:0] pattern_at(input int j);
        if (j < 8)
            return pat_lo[8*j +: 8];
        return pat_hi[8*(j-8) +: 8];
    endfunction

    // zero counts as one, anything past the window is clamped
    function automatic int active_len();
        int n;
        n = int'(pat_len);
        if (n == 0)
            n = 1;
        if (n > WIN_BYTES)
            n = WIN_BYTES;
        return n;
    endfunction

    function automatic void clear_window();
        for (int k = 0; k < WIN_BYTES; k++)
            window[k] = 8'h00;
        byte_pos = 0;
        answered = 1'b0;
    endfunction

    function automatic void track_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_W-1:0] value);
        case (idx)
            CFG_PAT_LO:  pat_lo = value;
            CFG_PAT_HI:  pat_hi = value;
            CFG_PAT_LEN: pat_len = value[LEN_W-1:0];
            CFG_START:   start_ofs = value[OFS_W-1:0];
            default: ;
        endcase
    endfunction

    // advance the window by one byte and queue the answer it triggers, if any
    function automatic void track_search_byte(input logic [7:0] b, input logic is_last);
        int          len;
        int unsigned s;
        bit          same;
        if (byte_pos < BUF_BYTES) begin
            for (int k = WIN_BYTES - 1; k > 0; k--)
                window[k] = window[k-1];
            window[0] = b;
            if (!answered) begin
                len = active_len();
                if (byte_pos + 1 >= len) begin
                    s = byte_pos + 1 - len;
                    if (s >= start_ofs) begin
                        same = 1'b1;
                        for (int j = 0; j < len; j++)
                            if (window[len-1-j] != pattern_at(j))
                                same = 1'b0;
                        if (same) begin
                            answered = 1'b1;
                            pending_answers.push_back('{found: 1'b1, offset: s[OFS_W-1:0]});
                        end
                    end
                end
            end
            byte_pos++;
        end
        if (is_last) begin
            if (!answered)
                pending_answers.push_back('{found: 1'b0, offset: '0});
            clear_window();
        end
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // drive one beat, opening a random gap whenever a burst runs out while gaps are on
    task automatic send_beat(input logic [7:0] b, input logic is_last);
        int gap;
        @(negedge i_clk);
        if (gaps_on && burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(1, 6);
            i_s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        if (burst_left > 0)
            burst_left--;
        i_s_tvalid = 1'b1;
        i_s_tdata  = b;
        i_s_tlast  = is_last;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        track_search_byte(b, is_last);
        beats_sent++;
        if (is_last)
            buffers_sent++;
    endtask

    // hold the sender until every answer is out, then let the pipe run dry
    task automatic settle_block();
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (pending_answers.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value;
        @(posedge i_clk);
        track_reg_write(idx, value);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // random search setup; mostly short patterns and low start offsets
    task automatic randomize_search_setup();
        logic [CFG_W-1:0] v;
        int pick;
        settle_block();
        v = {$urandom, $urandom};
        if ($urandom_range(0, 6) == 0)
            v = {8{v[7:0]}};
        write_reg(CFG_PAT_LO, v);
        v = {$urandom, $urandom};
        if ($urandom_range(0, 6) == 0)
            v = {8{v[7:0]}};
        write_reg(CFG_PAT_HI, v);
        pick = $urandom_range(0, 9);
        v = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : '0;
        if (pick < 7)
            v[LEN_W-1:0] = LEN_W'($urandom_range(1, 6));
        else if (pick == 7)
            v[LEN_W-1:0] = '0;
        else if (pick == 8)
            v[LEN_W-1:0] = LEN_W'(WIN_BYTES);
        else
            v[LEN_W-1:0] = LEN_W'($urandom_range(WIN_BYTES + 1, 31));
        write_reg(CFG_PAT_LEN, v);
        pick = $urandom_range(0, 9);
        v = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : '0;
        if (pick < 6)
            v[OFS_W-1:0] = '0;
        else if (pick < 9)
            v[OFS_W-1:0] = OFS_W'($urandom_range(1, 12));
        else
            v[OFS_W-1:0] = OFS_W'($urandom_range(20, 4095));
        write_reg(CFG_START, v);
    endtask

    // one short buffer: pattern-heavy filler, usually with whole or cut-off pattern copies
    task automatic send_random_buffer();
        logic [7:0] bytes_q[$];
        int n;
        int len;
        int at;
        int span;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 20);
        len = active_len();
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 1) == 0)
                bytes_q.push_back(8'($urandom_range(0, 255)));
            else
                bytes_q.push_back(pattern_at($urandom_range(0, len - 1)));
        end
        if ($urandom_range(0, 9) < 8 && n >= len) begin
            repeat ($urandom_range(1, 2)) begin
                at = $urandom_range(0, n - len);
                // some copies are cut short to break the match
                span = ($urandom_range(0, 4) == 0) ? $urandom_range(0, len - 1) : len;
                for (int j = 0; j < span; j++)
                    bytes_q[at + j] = pattern_at(j);
            end
        end
        gaps_on = ($urandom_range(0, 3) != 0);
        for (int i = 0; i < n; i++)
            send_beat(bytes_q[i], i == n - 1);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset pattern is one zero byte from offset zero
    task automatic test_reset_defaults();
        gaps_on = 1'b0;
        send_beat(8'h00, 1'b1);
        send_beat(8'hFF, 1'b1);
    endtask

    // length zero acts as one; an oversized length clamps to sixteen
    task automatic test_length_clamp();
        settle_block();
        write_reg(CFG_PAT_LO, 64'h0123_4567_89AB_CDEF);
        write_reg(CFG_PAT_HI, 64'hFEDC_BA98_7654_3210);
        write_reg(CFG_PAT_LEN, '0);
        write_reg(CFG_START, '0);
        send_beat(8'hEF, 1'b1);
        settle_block();
        write_reg(CFG_PAT_LEN, 64'd31);
        // full-width match that closes on the final byte
        gaps_on = 1'b1;
        for (int j = 0; j < WIN_BYTES; j++)
            send_beat(pattern_at(j), j == WIN_BYTES - 1);
    endtask

    // a start offset past the buffer end can only give not found
    task automatic test_start_past_end();
        settle_block();
        write_reg(CFG_PAT_LEN, 64'd1);
        write_reg(CFG_START, 64'hFFF);
        send_beat(8'hEF, 1'b0);
        send_beat(8'hEF, 1'b1);
    endtask

    // spare indexes must not disturb anything; a pattern swap inside a buffer applies at once
    task automatic test_spare_index_and_live_change();
        settle_block();
        write_reg(CFG_START, '0);
        for (int k = CFG_IDX_SPARE; k < 2**CFG_IDX_W; k++)
            write_reg(CFG_IDX_W'(k), '1);
        send_beat(8'h00, 1'b0);
        settle_block();
        write_reg(CFG_PAT_LO, 64'hAA);
        send_beat(8'hAA, 1'b1);
    endtask

    task automatic test_random_buffers();
        int stop_at;
        stop_at = beats_sent + RANDOM_BEATS;
        while (beats_sent < stop_at) begin
            if ($urandom_range(0, 3) == 0)
                randomize_search_setup();
            send_random_buffer();
        end
    endtask

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin : check_answer
        t_search_answer want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            answers_seen++;
            if (pending_answers.size() == 0) begin
                $error("unexpected result beat: found=%0d match_offset=%0d",
                       o_m_tuser, o_m_tdata[OFS_W-1:0]);
                mismatch_count++;
            end else begin
                want = pending_answers.pop_front();
                if (o_m_tuser !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, o_m_tuser);
                    mismatch_count++;
                end
                if (o_m_tdata[OFS_W-1:0] !== want.offset) begin
                    $error("match_offset: expected %0d, got %0d",
                           want.offset, o_m_tdata[OFS_W-1:0]);
                    mismatch_count++;
                end
            end
        end
    end

    // receiver backpressure in one of four styles, picked anew when the random hold runs out
    always @(negedge i_clk) begin
        if (rx_hold == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_hold = $urandom_range(20, 80);
        end
        rx_hold--;
        rx_tick++;
        case (rx_mode)
            RX_STEADY:   i_m_tready = 1'b1;
            RX_COIN:     i_m_tready = 1'($urandom_range(0, 1));
            RX_SPARSE:   i_m_tready = ($urandom_range(0, 5) == 0);
            RX_PERIODIC: i_m_tready = (rx_tick % 3 == 0);
            default:     i_m_tready = 1'b1;
        endcase
    end

    // end the run if no beat moves on either side for too long
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no beat moved for %0d cycles", IDLE_LIMIT);
            $display("** byte_pattern_first_match_unit: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------

    initial begin
        pat_lo         = '0;
        pat_hi         = '0;
        pat_len        = LEN_W'(1);
        start_ofs      = '0;
        clear_window();
        beats_sent     = 0;
        buffers_sent   = 0;
        answers_seen   = 0;
        mismatch_count = 0;
        idle_cycles    = 0;
        burst_left     = 0;
        gaps_on        = 1'b0;
        rx_hold        = 0;
        rx_tick        = 0;
        rx_mode        = RX_STEADY;

        // hold reset low before the tests start
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_length_clamp();
        test_start_past_end();
        test_spare_index_and_live_change();
        test_random_buffers();

        // drain outstanding answers, then watch the idle output a while
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (pending_answers.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYC) @(posedge i_clk);

        $display("covered %0d bytes in %0d buffers, with length clamps and live pattern swaps",
                 beats_sent, buffers_sent);
        $display("checked %0d result beats, %0d mismatches", answers_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("** byte_pattern_first_match_unit: PASSED **");
        else
            $display("** byte_pattern_first_match_unit: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/bpfm_pkg.sv
rtl/core/bpfm_cell.sv
rtl/core/bpfm_out_buf.sv
rtl/core/byte_pattern_first_match_unit.sv
verif/tb_byte_pattern_first_match_unit.sv
